// File: design/ipl_pkg.sv
// shared types and constants of the indexed point list
package ipl_pkg;

    localparam int CAPACITY_DEFAULT = 16;
    localparam int ACTION_W         = 3;
    localparam int POS_W            = 5;
    localparam int COORD_W          = 32;
    localparam int TOTAL_W          = 5;
    localparam int STATUS_W         = 2;
    localparam int GROUP_SIZE       = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_READ   = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic append_ok;
        logic insert_ok;
        logic remove_ok;
        logic read_ok;
    } cell_ctrl_t;

endpackage

// File: design/ipl_if.sv
// valid/ready channels for the request and result words
interface ipl_in_if;
    logic                                valid;
    logic                                ready;
    logic [ipl_pkg::ACTION_W-1:0]        action;
    logic [ipl_pkg::POS_W-1:0]           position;
    logic signed [ipl_pkg::COORD_W-1:0]  coord_x;
    logic signed [ipl_pkg::COORD_W-1:0]  coord_y;

    modport source (output valid, action, position, coord_x, coord_y, input ready);
    modport sink   (input valid, action, position, coord_x, coord_y, output ready);
endinterface

interface ipl_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ipl_pkg::COORD_W-1:0]  read_x;
    logic signed [ipl_pkg::COORD_W-1:0]  read_y;
    logic [ipl_pkg::TOTAL_W-1:0]         entry_total;
    logic [ipl_pkg::STATUS_W-1:0]        status;

    modport source (output valid, read_x, read_y, entry_total, status, input ready);
    modport sink   (input valid, read_x, read_y, entry_total, status, output ready);
endinterface

// File: design/indexed_point_list_top.sv
// indexed point list: a chain of slot cells with decode and a two-stage result path
//
// item channel (sink): one word per action - append, insert, remove, clear or read -
// with a position and the point to store. result channel (source): one word per
// action with the point read (zero unless a good read), the entry count after the
// action (low five bits) and a status code (ok, position out of range, list full).
// a word is moved when valid and ready are both high.
// every accepted item passes through the first stage and the result register; one item
// can be accepted every cycle unless the receiver stalls, since all slots shift together
// in the cycle of acceptance. read data is gathered over groups of sixteen slots in the
// first stage and the group results are combined in the second stage.
// reset empties the list; slot contents are undefined until written and are never
// returned before they are.
// when the receiver stalls, the result register holds its word and the first stage
// fills behind it; item ready then drops until the result is taken.
module indexed_point_list_top #(
    parameter int CAPACITY = ipl_pkg::CAPACITY_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    ipl_in_if.sink    item,
    ipl_out_if.source result
);
    import ipl_pkg::*;

    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int RD_SLOTS   = NUM_GROUPS * GROUP_SIZE;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [CMP_W-1:0]    pos_w;
    logic [CMP_W-1:0]    cnt_w;
    logic                full;
    logic                in_fire;
    action_t             action;
    status_t             status;
    cell_ctrl_t          ctrl;
    cell_ctrl_t          ctrl_gated;
    point_t              new_point;

    point_t              cell_pt [CAPACITY];
    point_t              cell_rd [RD_SLOTS];
    point_t              grp_or  [NUM_GROUPS];

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [TOTAL_W-1:0]  s1_total_reg;
    status_t             s1_status_reg;
    point_t              s1_grp_reg [NUM_GROUPS];
    logic                s1_advance;

    logic                out_valid_reg;
    logic                out_valid_next;
    point_t              out_point_reg;
    point_t              out_point_next;
    logic [TOTAL_W-1:0]  out_total_reg;
    status_t             out_status_reg;

    assign action     = action_t'(item.action);
    assign pos_w      = CMP_W'(item.position);
    assign cnt_w      = CMP_W'(cnt_reg);
    assign full       = (cnt_reg == CAP_CNT);
    assign new_point  = '{x: item.coord_x, y: item.coord_y};

    assign s1_advance = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_advance;
    assign in_fire    = item.valid && item.ready;

    // action decode
    always_comb
    begin
        ctrl     = '0;
        status   = ST_OK;
        cnt_next = cnt_reg;
        unique case (action)
            ACT_APPEND:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctrl.append_ok = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                end
            end
            ACT_INSERT:
            begin
                if (pos_w > cnt_w)
                begin
                    status = ST_RANGE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctrl.insert_ok = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                if (pos_w >= cnt_w)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    ctrl.remove_ok = 1'b1;
                    cnt_next       = cnt_reg - 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                cnt_next = '0;
            end
            ACT_READ:
            begin
                if (pos_w >= cnt_w)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    ctrl.read_ok = 1'b1;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    assign ctrl_gated = in_fire ? ctrl : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (in_fire)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // slot chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        point_t left_point;
        point_t right_point;

        if (i == 0)
        begin : g_first
            assign left_point = '0;
        end
        else
        begin : g_mid_l
            assign left_point = cell_pt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_point = '0;
        end
        else
        begin : g_mid_r
            assign right_point = cell_pt[i+1];
        end

        ipl_cell #(
            .CMP_W (CMP_W),
            .IDX   (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl_gated),
            .pos         (pos_w),
            .count       (cnt_w),
            .new_point   (new_point),
            .left_point  (left_point),
            .right_point (right_point),
            .point       (cell_pt[i]),
            .read_point  (cell_rd[i])
        );
    end

    for (genvar i = CAPACITY; i < RD_SLOTS; i++)
    begin : g_pad
        assign cell_rd[i] = '0;
    end

    // read gather, first level
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_or[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                grp_or[g] = grp_or[g] | cell_rd[g*GROUP_SIZE + k];
            end
        end
    end

    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_total_reg  <= TOTAL_W'(cnt_next);
            s1_status_reg <= status;
            s1_grp_reg    <= grp_or;
        end
    end

    // read gather, second level
    always_comb
    begin
        out_point_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            out_point_next = out_point_next | s1_grp_reg[g];
        end
    end

    assign out_valid_next = s1_advance || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_point_reg  <= out_point_next;
            out_total_reg  <= s1_total_reg;
            out_status_reg <= s1_status_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.read_x      = out_point_reg.x;
    assign result.read_y      = out_point_reg.y;
    assign result.entry_total = out_total_reg;
    assign result.status      = out_status_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(cnt_reg))
        else $error("entry count moved without an accepted word");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && action == ACT_CLEAR) |=> (cnt_reg == '0))
        else $error("clear left entries behind");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |-> (!in_fire ##1 s1_valid_reg))
        else $error("first stage lost or overwritten while stalled");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && status == ST_FULL) |-> full)
        else $error("full reported with room left");

endmodule

// File: design/ipl_cell.sv
// one list slot: holds a point and shifts to or from its neighbours
module ipl_cell #(
    parameter int CMP_W = 5,
    parameter int IDX   = 0
) (
    input  logic                clk,
    input  ipl_pkg::cell_ctrl_t ctrl,
    input  logic [CMP_W-1:0]    pos,
    input  logic [CMP_W-1:0]    count,
    input  ipl_pkg::point_t     new_point,
    input  ipl_pkg::point_t     left_point,
    input  ipl_pkg::point_t     right_point,
    output ipl_pkg::point_t     point,
    output ipl_pkg::point_t     read_point
);
    import ipl_pkg::*;

    localparam logic [CMP_W-1:0] MY_IDX    = CMP_W'(IDX);
    localparam logic [CMP_W-1:0] MY_IDX_P1 = CMP_W'(IDX + 1);

    point_t point_reg;
    point_t point_next;
    logic   load;
    logic   shift_up;
    logic   shift_down;
    logic   hit;

    assign load       = (ctrl.append_ok && (MY_IDX == count))
                     || (ctrl.insert_ok && (MY_IDX == pos));
    assign shift_up   = ctrl.insert_ok && (MY_IDX > pos) && (MY_IDX <= count);
    assign shift_down = ctrl.remove_ok && (MY_IDX >= pos) && (MY_IDX_P1 < count);
    assign hit        = ctrl.read_ok && (MY_IDX == pos);

    always_comb
    begin
        point_next = point_reg;
        if (load)
        begin
            point_next = new_point;
        end
        else if (shift_up)
        begin
            point_next = left_point;
        end
        else if (shift_down)
        begin
            point_next = right_point;
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
    end

    assign point      = point_reg;
    assign read_point = hit ? point_reg : '0;

endmodule

// File: tb/ipl_checker.sv
// checker for the indexed point list: watches both channels, predicts each result and compares
module ipl_checker #(
    parameter int CAPACITY = ipl_pkg::CAPACITY_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    ipl_in_if    item,
    ipl_out_if   result,
    output int   mismatches,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ipl_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] read_x;
        logic signed [COORD_W-1:0] read_y;
        logic [TOTAL_W-1:0]        entry_total;
        status_t                   status;
    } list_outcome_t;

    point_t        points [CAPACITY];
    int            point_count;
    list_outcome_t awaited [$];

    function automatic list_outcome_t apply_action(
        logic [ACTION_W-1:0]       act,
        logic [POS_W-1:0]          pos,
        logic signed [COORD_W-1:0] cx,
        logic signed [COORD_W-1:0] cy
    );
        list_outcome_t res;
        int            idx;
        int            i;
        res.read_x = '0;
        res.read_y = '0;
        res.status = ST_OK;
        idx = int'(pos);
        case (act)
            ACT_APPEND:
            begin
                if (point_count >= CAPACITY)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    points[point_count] = '{x: cx, y: cy};
                    point_count++;
                end
            end
            ACT_INSERT:
            begin
                if (idx > point_count)
                begin
                    res.status = ST_RANGE;
                end
                else if (point_count >= CAPACITY)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    for (i = point_count; i > idx; i--)
                    begin
                        points[i] = points[i-1];
                    end
                    points[idx] = '{x: cx, y: cy};
                    point_count++;
                end
            end
            ACT_REMOVE:
            begin
                if (idx >= point_count)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    for (i = idx; i + 1 < point_count; i++)
                    begin
                        points[i] = points[i+1];
                    end
                    point_count--;
                end
            end
            ACT_CLEAR:
            begin
                point_count = 0;
            end
            ACT_READ:
            begin
                if (idx >= point_count)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    res.read_x = points[idx].x;
                    res.read_y = points[idx].y;
                end
            end
            default:
            begin
            end
        endcase
        res.entry_total = TOTAL_W'(point_count);
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_outcome_t want;
        if (!rst_n)
        begin
            point_count = 0;
            awaited.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (awaited.size() == 0)
                begin
                    report_mismatch("unexpected result word, entry_total", result.entry_total, -1);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (result.read_x !== want.read_x)
                        report_mismatch("read_x", result.read_x, want.read_x);
                    if (result.read_y !== want.read_y)
                        report_mismatch("read_y", result.read_y, want.read_y);
                    if (result.entry_total !== want.entry_total)
                        report_mismatch("entry_total", result.entry_total, want.entry_total);
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                end
            end
            if (item.valid && item.ready)
            begin
                awaited.insert(awaited.size(), apply_action(item.action, item.position,
                                                            item.coord_x, item.coord_y));
            end
            pending = awaited.size();
        end
    end

endmodule

// File: tb/tb.sv
// top of the indexed point list testbench: clock, reset, request stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipl_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEFAULT;
    localparam int RANDOM_ITEMS = 1120;
    localparam int CALM_ITEMS   = 150;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [ACTION_W-1:0]       ACT_UNUSED_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0]       ACT_UNUSED_LAST  = 3'd7;
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_NOISE} stim_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int mismatches;
    int pending;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int list_fill   = 0;
    int cycle_count = 0;

    ipl_in_if  item ();
    ipl_out_if result ();

    always #5 clk = ~clk;

    indexed_point_list_top #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    ipl_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(9, 0))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(
        logic [ACTION_W-1:0]       act,
        logic [POS_W-1:0]          pos,
        logic signed [COORD_W-1:0] cx,
        logic signed [COORD_W-1:0] cy
    );
        int gap;
        if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            gap = $urandom_range(7, 1);
            item.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.valid    <= 1'b1;
        item.action   <= act;
        item.position <= pos;
        item.coord_x  <= cx;
        item.coord_y  <= cy;
        @(posedge clk);
        while (!item.ready) @(posedge clk);
        case (act)
            ACT_APPEND: if (list_fill < CAPACITY) list_fill++;
            ACT_INSERT: if (int'(pos) <= list_fill && list_fill < CAPACITY) list_fill++;
            ACT_REMOVE: if (int'(pos) < list_fill) list_fill--;
            ACT_CLEAR:  list_fill = 0;
            default:    ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // result side: random stall bursts
    initial
    begin
        int hold;
        hold = 0;
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (stall_pct > 0 && $urandom_range(99, 0) < stall_pct)
                hold = $urandom_range(7, 1);
            result.ready <= (hold == 0);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int                        k;
        int                        n;
        int                        burst_left;
        stim_mode_t                mode;
        logic [ACTION_W-1:0]       act;
        logic [POS_W-1:0]          pos;
        logic signed [COORD_W-1:0] cx;

        item.valid    = 1'b0;
        item.action   = ACT_APPEND;
        item.position = '0;
        item.coord_x  = '0;
        item.coord_y  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fill to capacity, extremes of both coordinates on the way
        for (k = 0; k < CAPACITY; k++)
        begin
            cx = k[0] ? COORD_MAX - k : COORD_MIN + k;
            send_word(ACT_APPEND, POS_W'($urandom), cx, ~cx);
        end
        send_word(ACT_APPEND, '0, COORD_MAX, COORD_MAX);
        send_word(ACT_INSERT, '0, COORD_MIN, COORD_MIN);
        send_word(ACT_INSERT, POS_W'(CAPACITY + 1), '1, '1);
        send_word(ACT_READ, POS_W'(CAPACITY - 1), '0, '0);
        send_word(ACT_REMOVE, {POS_W{1'b1}}, '0, '0);
        send_word(ACT_REMOVE, '0, '0, '0);
        send_word(ACT_INSERT, POS_W'(CAPACITY - 1), 32'sh1234_5678, -32'sd99);
        for (k = ACT_UNUSED_FIRST; k <= ACT_UNUSED_LAST; k++)
        begin
            send_word(ACTION_W'(k), {POS_W{1'b1}}, '1, '1);
        end
        send_word(ACT_CLEAR, '0, '0, '0);
        send_word(ACT_READ, '0, '0, '0);
        send_word(ACT_INSERT, '0, 32'sd7, -32'sd7);
        send_word(ACT_INSERT, '0, COORD_MIN, COORD_MAX);
        send_word(ACT_READ, 5'd1, '0, '0);

        wait_drained();

        burst_left = 0;
        mode = MODE_MIXED;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (burst_left == 0)
            begin
                case ($urandom_range(99, 0)) inside
                    [0:29]:  mode = MODE_GROW;
                    [30:54]: mode = MODE_SHRINK;
                    [55:89]: mode = MODE_MIXED;
                    default: mode = MODE_NOISE;
                endcase
                burst_left = $urandom_range(40, 4);
                idle_pct  = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(50, 10);
                stall_pct = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(50, 10);
            end
            if (n >= RANDOM_ITEMS - CALM_ITEMS)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            if (n == RANDOM_ITEMS / 2)
                wait_drained();

            case (mode)
                MODE_GROW:
                    act = ($urandom_range(9, 0) < 5) ? ACT_APPEND :
                          ($urandom_range(9, 0) < 8) ? ACT_INSERT : ACT_READ;
                MODE_SHRINK:
                    act = ($urandom_range(9, 0) < 6) ? ACT_REMOVE : ACT_READ;
                MODE_MIXED:
                    case ($urandom_range(32, 0)) inside
                        0:       act = ACT_CLEAR;
                        [1:8]:   act = ACT_APPEND;
                        [9:16]:  act = ACT_INSERT;
                        [17:24]: act = ACT_REMOVE;
                        default: act = ACT_READ;
                    endcase
                default:
                    act = ACTION_W'($urandom);
            endcase

            if (mode == MODE_NOISE)
                pos = POS_W'($urandom);
            else if (act == ACT_INSERT || act == ACT_APPEND)
                pos = POS_W'($urandom_range(list_fill, 0));
            else if (list_fill == 0)
                pos = '0;
            else
                pos = POS_W'($urandom_range(list_fill - 1, 0));

            send_word(act, pos, pick_coord(), pick_coord());
            burst_left--;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
